[design/bpd_pkg.sv]
// Shared widths, status codes and result type for the braid to PD crossing converter.
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int ARC_W   = 12;
    localparam int CNT_W   = 11;
    localparam int GEN_W   = 7;
    localparam int SC_W    = 7;

    localparam int MAX_STRANDS_DEF   = 64;
    localparam int MAX_CROSSINGS_DEF = 1024;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_GEN  = 2'd1,
        ST_OVERFLOW = 2'd2
    } bpd_status_t;

    typedef struct packed {
        logic [ARC_W-1:0] slot_a;
        logic [ARC_W-1:0] slot_b;
        logic [ARC_W-1:0] slot_c;
        logic [ARC_W-1:0] slot_d;
        logic             is_negative;
        bpd_status_t      status;
    } crossing_t;

endpackage

[design/bpd_if.sv]
// Valid/ready channel interfaces for generator input and crossing output.
`timescale 1ns / 1ps

interface bpd_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [6:0]       generator;
    logic                    word_start;

    modport source (output valid, output generator, output word_start, input ready);
    modport sink   (input valid, input generator, input word_start, output ready);
endinterface

interface bpd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] slot_a;
    logic [11:0] slot_b;
    logic [11:0] slot_c;
    logic [11:0] slot_d;
    logic        is_negative;
    logic [1:0]  status;

    modport source (output valid, output slot_a, output slot_b, output slot_c,
                    output slot_d, output is_negative, output status, input ready);
    modport sink   (input valid, input slot_a, input slot_b, input slot_c,
                    input slot_d, input is_negative, input status, output ready);
endinterface

[design/bpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bpd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/bpd_out_reg.sv]
// Output register that holds one finished crossing until the sink takes it.
`timescale 1ns / 1ps

module bpd_out_reg
    import bpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  crossing_t  res_data,
    output logic       res_ready,
    bpd_out_if.source  out_ch
);

    logic      valid_reg;
    logic      valid_next;
    crossing_t data_reg;

    assign res_ready  = !valid_reg || out_ch.ready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res_data;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.slot_a      = data_reg.slot_a;
    assign out_ch.slot_b      = data_reg.slot_b;
    assign out_ch.slot_c      = data_reg.slot_c;
    assign out_ch.slot_d      = data_reg.slot_d;
    assign out_ch.is_negative = data_reg.is_negative;
    assign out_ch.status      = data_reg.status;

endmodule

[design/braid_to_pd_crossings.sv]
// Top level of the braid word to planar-diagram crossing converter.
`timescale 1ns / 1ps

// This block turns a braid word, one signed generator per transaction, into
// planar-diagram crossings: for every generator it returns one transaction with
// four arc numbers, the crossing sign and a status code. A generator is taken
// in every clock cycle as long as the output side keeps up; each one passes
// through the lookup stage, where the two strand arcs come out of the strand
// memory, and then waits in the output register until the sink takes it. The
// arcs on the strands live in two RAM banks, one for even and one for odd
// strand positions, since a crossing always touches one strand of each
// parity; a flip-flop per strand marks which positions hold a written arc,
// and a position never written since the last word start reads as its own
// index. Setting word_start clears those marks, restarts the arc counter at
// the strand count and clears the crossing count. A zero or out-of-range
// generator returns status 1, and more than MAX_CROSSINGS crossings in a word
// returns status 2; either leaves the arcs at zero and writes nothing to the
// strand memory. The strand count register may only be written while no
// transaction is in flight.

module braid_to_pd_crossings
    import bpd_pkg::*;
#(
    parameter int MAX_STRANDS   = MAX_STRANDS_DEF,
    parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [SC_W-1:0] cfg_wdata,
    bpd_in_if.sink          gen_ch,
    bpd_out_if.source       crossing_ch
);

    // Strand index width and the geometry of the two parity banks.
    localparam int PW         = $clog2(MAX_STRANDS);
    localparam int BANK_DEPTH = (MAX_STRANDS + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Configuration.
    logic [SC_W-1:0] strand_count_reg;

    // Lookup stage registers.
    logic             s1_valid_reg;
    logic [6:0]       s1_mag_reg;
    logic             s1_neg_reg;
    logic             s1_ws_reg;
    logic             fwd_even_reg;
    logic             fwd_odd_reg;
    logic [ARC_W-1:0] fwd_even_data_reg;
    logic [ARC_W-1:0] fwd_odd_data_reg;

    // Architectural state.
    logic [MAX_STRANDS-1:0] written_reg;
    logic [MAX_STRANDS-1:0] written_next;
    logic [ARC_W-1:0]       next_arc_reg;
    logic [ARC_W-1:0]       next_arc_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Input decode.
    logic [6:0]     in_raw;
    logic [6:0]     in_mag;
    logic [6:0]     in_mag_m1;
    logic [BAW-1:0] even_raddr;
    logic [BAW-1:0] odd_raddr;
    logic           accept;

    // Lookup stage logic.
    logic [ARC_W-1:0] even_rdata;
    logic [ARC_W-1:0] odd_rdata;
    logic [ARC_W-1:0] even_data;
    logic [ARC_W-1:0] odd_data;
    logic [ARC_W-1:0] lo_data;
    logic [ARC_W-1:0] hi_data;
    logic [6:0]       n_eff;
    logic [6:0]       s1_lo;
    logic [PW-1:0]    lo_idx;
    logic [PW-1:0]    hi_idx;
    logic [ARC_W-1:0] under_in;
    logic [ARC_W-1:0] over_in;
    logic [ARC_W-1:0] next_eff;
    logic [ARC_W-1:0] under_new;
    logic [ARC_W-1:0] over_new;
    logic [CNT_W-1:0] count_eff;
    bpd_status_t      s1_status;
    crossing_t        s1_result;
    logic             s1_adv;
    logic             commit;
    logic             commit_ok;

    // Bank write ports.
    logic [BAW-1:0]   even_waddr;
    logic [BAW-1:0]   odd_waddr;
    logic [ARC_W-1:0] even_wdata;
    logic [ARC_W-1:0] odd_wdata;

    // The negative generator magnitude is the two's complement of the raw code.
    assign in_raw    = gen_ch.generator;
    assign in_mag    = in_raw[6] ? (7'd0 - in_raw) : in_raw;
    assign in_mag_m1 = in_mag - 7'd1;

    // Even position is mag with its low bit cleared, odd position the other of the pair.
    assign even_raddr = BAW'(in_mag >> 1);
    assign odd_raddr  = BAW'(in_mag_m1 >> 1);

    assign gen_ch.ready = !s1_valid_reg || s1_adv;
    assign accept       = gen_ch.valid && gen_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_count_reg <= SC_W'(2);
        end
        else if (cfg_we)
        begin
            strand_count_reg <= cfg_wdata;
        end
    end

    // Clamp the configured strand count into the supported range.
    always_comb
    begin
        if (strand_count_reg < 7'd2)
        begin
            n_eff = 7'd2;
        end
        else if (strand_count_reg > 7'(MAX_STRANDS))
        begin
            n_eff = 7'(MAX_STRANDS);
        end
        else
        begin
            n_eff = strand_count_reg;
        end
    end

    // A crossing on strands lo and hi: with odd mag, lo is the even one.
    assign s1_lo     = s1_mag_reg - 7'd1;
    assign lo_idx    = PW'(s1_lo);
    assign hi_idx    = PW'(s1_mag_reg);
    assign even_data = fwd_even_reg ? fwd_even_data_reg : even_rdata;
    assign odd_data  = fwd_odd_reg  ? fwd_odd_data_reg  : odd_rdata;
    assign lo_data   = s1_mag_reg[0] ? even_data : odd_data;
    assign hi_data   = s1_mag_reg[0] ? odd_data  : even_data;

    // A word start makes every strand read as its own index.
    assign under_in  = (!s1_ws_reg && written_reg[lo_idx]) ? lo_data : ARC_W'(s1_lo);
    assign over_in   = (!s1_ws_reg && written_reg[hi_idx]) ? hi_data : ARC_W'(s1_mag_reg);
    assign next_eff  = s1_ws_reg ? ARC_W'(n_eff) : next_arc_reg;
    assign count_eff = s1_ws_reg ? '0 : count_reg;
    assign under_new = next_eff;
    assign over_new  = next_eff + ARC_W'(1);

    always_comb
    begin
        if (s1_mag_reg == 7'd0 || s1_mag_reg >= n_eff)
        begin
            s1_status = ST_BAD_GEN;
        end
        else if (count_eff >= CNT_W'(MAX_CROSSINGS))
        begin
            s1_status = ST_OVERFLOW;
        end
        else
        begin
            s1_status = ST_OK;
        end
    end

    // Negative crossings swap under and over in both pairs.
    always_comb
    begin
        s1_result        = '0;
        s1_result.status = s1_status;
        if (s1_status == ST_OK)
        begin
            s1_result.is_negative = s1_neg_reg;
            if (s1_neg_reg)
            begin
                s1_result.slot_a = over_in;
                s1_result.slot_b = under_in;
                s1_result.slot_c = over_new;
                s1_result.slot_d = under_new;
            end
            else
            begin
                s1_result.slot_a = under_in;
                s1_result.slot_b = over_in;
                s1_result.slot_c = under_new;
                s1_result.slot_d = over_new;
            end
        end
    end

    assign commit    = s1_valid_reg && s1_adv;
    assign commit_ok = commit && (s1_status == ST_OK);

    assign even_waddr = BAW'(s1_mag_reg >> 1);
    assign odd_waddr  = BAW'(s1_lo >> 1);
    assign even_wdata = s1_mag_reg[0] ? under_new : over_new;
    assign odd_wdata  = s1_mag_reg[0] ? over_new  : under_new;

    // State update when the lookup stage hands its transaction on.
    always_comb
    begin
        written_next  = written_reg;
        next_arc_next = next_arc_reg;
        count_next    = count_reg;
        if (commit)
        begin
            if (s1_ws_reg)
            begin
                written_next  = '0;
                next_arc_next = ARC_W'(n_eff);
                count_next    = '0;
            end
            if (commit_ok)
            begin
                for (int p = 0; p < MAX_STRANDS; p++)
                begin
                    if (PW'(p) == lo_idx || PW'(p) == hi_idx)
                    begin
                        written_next[p] = 1'b1;
                    end
                end
                next_arc_next = next_eff + ARC_W'(2);
                count_next    = count_eff + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
            next_arc_reg <= '0;
            count_reg    <= '0;
            fwd_even_reg <= 1'b0;
            fwd_odd_reg  <= 1'b0;
        end
        else
        begin
            written_reg  <= written_next;
            next_arc_reg <= next_arc_next;
            count_reg    <= count_next;
            if (gen_ch.ready)
            begin
                s1_valid_reg <= gen_ch.valid;
            end
            // The bank read at acceptance misses a write made at the same edge.
            if (accept)
            begin
                fwd_even_reg <= commit_ok && (even_waddr == even_raddr);
                fwd_odd_reg  <= commit_ok && (odd_waddr == odd_raddr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg        <= in_mag;
            s1_neg_reg        <= in_raw[6];
            s1_ws_reg         <= gen_ch.word_start;
            fwd_even_data_reg <= even_wdata;
            fwd_odd_data_reg  <= odd_wdata;
        end
    end

    bpd_ram #(
        .WIDTH (ARC_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (commit_ok),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (accept),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    bpd_ram #(
        .WIDTH (ARC_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (commit_ok),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (accept),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    bpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (s1_valid_reg),
        .res_data  (s1_result),
        .res_ready (s1_adv),
        .out_ch    (crossing_ch)
    );

    // A rejected generator never carries arc numbers or a sign.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (crossing_ch.valid && crossing_ch.status != ST_OK) |->
        (crossing_ch.slot_a == '0 && crossing_ch.slot_b == '0 &&
         crossing_ch.slot_c == '0 && crossing_ch.slot_d == '0 &&
         !crossing_ch.is_negative))
        else $error("error transaction carries nonzero arcs");

    // The crossing count never runs past its limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CROSSINGS))
        else $error("crossing count beyond limit");

    // Each good crossing inside a word allocates exactly two arcs.
    a_arc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_ok && !s1_ws_reg) |=>
        next_arc_reg == $past(next_arc_reg) + ARC_W'(2))
        else $error("arc counter did not advance by two");

    // An empty lookup stage always takes a new transaction.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> gen_ch.ready)
        else $error("input stalled with empty lookup stage");

endmodule
